@@ design/qerv_pkg.sv @@
// shared types, constants and the arctangent table for the quaternion box-minus block
`default_nettype none
package qerv_pkg;

  localparam int FrontStages  = 5;   // saturate/multiply, sum/round, flip, square, 1 - c^2
  localparam int SqrtSteps    = 32;  // one binary root digit per stage
  localparam int CordicSteps  = 60;  // one vectoring step per stage
  localparam int DivSteps     = 32;  // one quotient bit per stage

  localparam logic signed [30:0] RotLimit = 31'sd843314857;
  localparam logic [63:0] One60 = 64'h1000_0000_0000_0000;

  // difference quaternion parts after rounding, range [-2^32, 2^32]
  typedef logic signed [33:0] vec_t;

  // vector part that rides along the pipeline
  typedef struct packed {
    vec_t vx;
    vec_t vy;
    vec_t vz;
  } side_t;

  typedef logic [63:0] atan_arr_t [CordicSteps];

  // unsigned long division by shift and subtract, elaboration only
  function automatic logic [63:0] udiv64(input logic [63:0] A, input logic [63:0] B);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[63:0], A[i]};
      if (r >= {1'b0, B}) begin
        r    = r - {1'b0, B};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // atan(1/N) in Q.60 by the truncated series, elaboration only
  function automatic logic [63:0] atan_recip(input logic [63:0] N);
    logic [63:0] nn;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] k;
    logic [63:0] q;
    nn   = N * N;
    term = udiv64(One60, N);
    sum  = '0;
    k    = '0;
    while (term != 64'd0) begin
      q = udiv64(term, 64'd2 * k + 64'd1);
      if (k[0]) sum = sum - q;
      else sum = sum + q;
      term = udiv64(term, nn);
      k = k + 64'd1;
    end
    return sum;
  endfunction

  function automatic logic [63:0] atan_entry(input int I);
    if (I == 0) return 64'd4 * atan_recip(64'd5) - atan_recip(64'd239);
    else if (I <= 30) return atan_recip(64'd1 << I);
    else return One60 >> I;
  endfunction

  function automatic atan_arr_t build_atan();
    atan_arr_t tab;
    for (int i = 0; i < CordicSteps; i++) begin
      tab[i] = atan_entry(i);
    end
    return tab;
  endfunction

endpackage
`default_nettype wire

@@ design/qerv_front.sv @@
// front end: saturation, quaternion product, sign flip, clamp and 4*(1 - c^2)
`default_nettype none
module qerv_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_vld,
  input  logic [255:0]         in_data,
  output logic                 out_vld,
  output logic [30:0]          out_c,
  output logic [62:0]          out_a,
  output qerv_pkg::side_t      out_side
);

  function automatic logic signed [31:0] sat_q30(input logic [31:0] raw);
    logic signed [31:0] v;
    v = $signed(raw);
    if (v > 32'sd1073741824) return 32'sd1073741824;
    else if (v < -32'sd1073741824) return -32'sd1073741824;
    else return v;
  endfunction

  function automatic logic signed [61:0] mul(input logic signed [31:0] p,
                                             input logic signed [31:0] q);
    logic signed [63:0] full;
    full = p * q;
    return full[61:0];
  endfunction

  logic [qerv_pkg::FrontStages-1:0] vld_r;

  logic signed [61:0] prod_r [16];
  logic signed [61:0] prod_nxt [16];
  qerv_pkg::vec_t     d_r [4];
  qerv_pkg::vec_t     d_nxt [4];
  qerv_pkg::vec_t     df_nxt [4];
  logic [30:0]        c_r, c_nxt;
  logic [30:0]        c2_r;
  logic [60:0]        cc_r, cc_nxt;
  qerv_pkg::side_t    side3_r, side4_r, side5_r;
  logic [62:0]        a_r, a_nxt;
  logic [30:0]        c5_r;

  // stage 1: saturate, conjugate the reference, sixteen products
  always_comb begin
    logic signed [31:0] aw, ax, ay, az, bw, bx, by, bz;
    aw = sat_q30(in_data[4*32 +: 32]);
    ax = sat_q30(in_data[5*32 +: 32]);
    ay = sat_q30(in_data[6*32 +: 32]);
    az = sat_q30(in_data[7*32 +: 32]);
    bw = sat_q30(in_data[0*32 +: 32]);
    bx = -sat_q30(in_data[1*32 +: 32]);
    by = -sat_q30(in_data[2*32 +: 32]);
    bz = -sat_q30(in_data[3*32 +: 32]);
    prod_nxt[0]  = mul(aw, bw);
    prod_nxt[1]  = mul(ax, bx);
    prod_nxt[2]  = mul(ay, by);
    prod_nxt[3]  = mul(az, bz);
    prod_nxt[4]  = mul(aw, bx);
    prod_nxt[5]  = mul(ax, bw);
    prod_nxt[6]  = mul(ay, bz);
    prod_nxt[7]  = mul(az, by);
    prod_nxt[8]  = mul(aw, by);
    prod_nxt[9]  = mul(ay, bw);
    prod_nxt[10] = mul(az, bx);
    prod_nxt[11] = mul(ax, bz);
    prod_nxt[12] = mul(aw, bz);
    prod_nxt[13] = mul(az, bw);
    prod_nxt[14] = mul(ax, by);
    prod_nxt[15] = mul(ay, bx);
  end

  // stage 2: four-term sums rounded to q4.30
  always_comb begin
    logic signed [63:0] sum [4];
    logic signed [63:0] rnd;
    sum[0] = 64'(prod_r[0]) - 64'(prod_r[1]) - 64'(prod_r[2]) - 64'(prod_r[3]);
    sum[1] = 64'(prod_r[4]) + 64'(prod_r[5]) + 64'(prod_r[6]) - 64'(prod_r[7]);
    sum[2] = 64'(prod_r[8]) + 64'(prod_r[9]) + 64'(prod_r[10]) - 64'(prod_r[11]);
    sum[3] = 64'(prod_r[12]) + 64'(prod_r[13]) + 64'(prod_r[14]) - 64'(prod_r[15]);
    for (int j = 0; j < 4; j++) begin
      rnd = (sum[j] + 64'sd536870912) >>> 30;
      d_nxt[j] = rnd[33:0];
    end
  end

  // stage 3: take the short way round, clamp the scalar part
  always_comb begin
    for (int j = 0; j < 4; j++) begin
      df_nxt[j] = d_r[0][33] ? -d_r[j] : d_r[j];
    end
    if (df_nxt[0] > 34'sd1073741824) c_nxt = 31'h4000_0000;
    else c_nxt = df_nxt[0][30:0];
  end

  // stage 4: c squared
  assign cc_nxt = 61'(62'(c_r) * 62'(c_r));

  // stage 5: 4 * (2^60 - c^2)
  always_comb begin
    logic [60:0] diff;
    diff  = 61'(qerv_pkg::One60) - cc_r;
    a_nxt = {diff, 2'b00};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[qerv_pkg::FrontStages-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r  <= prod_nxt;
      d_r     <= d_nxt;
      c_r     <= c_nxt;
      side3_r <= '{vx: df_nxt[1], vy: df_nxt[2], vz: df_nxt[3]};
      cc_r    <= cc_nxt;
      c2_r    <= c_r;
      side4_r <= side3_r;
      a_r     <= a_nxt;
      c5_r    <= c2_r;
      side5_r <= side4_r;
    end
  end

  assign out_vld  = vld_r[qerv_pkg::FrontStages-1];
  assign out_c    = c5_r;
  assign out_a    = a_r;
  assign out_side = side5_r;

endmodule
`default_nettype wire

@@ design/qerv_sqrt.sv @@
// pipelined integer square root, one root digit per stage
`default_nettype none
module qerv_sqrt (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_vld,
  input  logic [62:0]      in_a,
  input  logic [30:0]      in_c,
  input  qerv_pkg::side_t  in_side,
  output logic             out_vld,
  output logic [31:0]      out_s,
  output logic [30:0]      out_c,
  output qerv_pkg::side_t  out_side
);

  localparam int N = qerv_pkg::SqrtSteps;

  logic [N-1:0]     vld_r, vld_nxt;
  logic [62:0]      rem_r [N];
  logic [62:0]      rem_nxt [N];
  logic [62:0]      root_r [N];
  logic [62:0]      root_nxt [N];
  logic [30:0]      c_r [N];
  logic [30:0]      c_nxt [N];
  qerv_pkg::side_t  side_r [N];
  qerv_pkg::side_t  side_nxt [N];

  always_comb begin
    for (int k = 0; k < N; k++) begin
      logic [62:0] rem_i;
      logic [62:0] root_i;
      logic [62:0] bitv;
      logic [63:0] trial;
      bitv = 63'(64'd1 << (62 - 2 * k));
      if (k == 0) begin
        rem_i       = in_a;
        root_i      = '0;
        vld_nxt[k]  = in_vld;
        c_nxt[k]    = in_c;
        side_nxt[k] = in_side;
      end else begin
        rem_i       = rem_r[k-1];
        root_i      = root_r[k-1];
        vld_nxt[k]  = vld_r[k-1];
        c_nxt[k]    = c_r[k-1];
        side_nxt[k] = side_r[k-1];
      end
      trial = {1'b0, root_i} + {1'b0, bitv};
      if ({1'b0, rem_i} >= trial) begin
        rem_nxt[k]  = rem_i - trial[62:0];
        root_nxt[k] = (root_i >> 1) + bitv;
      end else begin
        rem_nxt[k]  = rem_i;
        root_nxt[k] = root_i >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
      c_r    <= c_nxt;
      side_r <= side_nxt;
    end
  end

  assign out_vld  = vld_r[N-1];
  assign out_s    = root_r[N-1][31:0];
  assign out_c    = c_r[N-1];
  assign out_side = side_r[N-1];

endmodule
`default_nettype wire

@@ design/qerv_cordic.sv @@
// pipelined cordic vectoring: half angle atan2(s, c) in q.60
`default_nettype none
module qerv_cordic (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_vld,
  input  logic [30:0]        in_c,
  input  logic [31:0]        in_s,
  input  qerv_pkg::side_t    in_side,
  output logic               out_vld,
  output logic signed [63:0] out_t,
  output logic [31:0]        out_s,
  output qerv_pkg::side_t    out_side
);

  localparam int N = qerv_pkg::CordicSteps;
  localparam qerv_pkg::atan_arr_t AtanTab = qerv_pkg::build_atan();

  logic [N-1:0]       vld_r, vld_nxt;
  logic signed [63:0] x_r [N];
  logic signed [63:0] x_nxt [N];
  logic signed [63:0] y_r [N];
  logic signed [63:0] y_nxt [N];
  logic signed [63:0] z_r [N];
  logic signed [63:0] z_nxt [N];
  logic [31:0]        s_r [N];
  logic [31:0]        s_nxt [N];
  qerv_pkg::side_t    side_r [N];
  qerv_pkg::side_t    side_nxt [N];

  always_comb begin
    for (int k = 0; k < N; k++) begin
      logic signed [63:0] xi, yi, zi, dx, dy, ang;
      if (k == 0) begin
        xi          = $signed(64'(in_c) << 30);
        yi          = $signed(64'(in_s) << 29);
        zi          = '0;
        vld_nxt[k]  = in_vld;
        s_nxt[k]    = in_s;
        side_nxt[k] = in_side;
      end else begin
        xi          = x_r[k-1];
        yi          = y_r[k-1];
        zi          = z_r[k-1];
        vld_nxt[k]  = vld_r[k-1];
        s_nxt[k]    = s_r[k-1];
        side_nxt[k] = side_r[k-1];
      end
      dx  = yi >>> k;
      dy  = xi >>> k;
      ang = $signed(AtanTab[k]);
      if (yi > 64'sd0) begin
        x_nxt[k] = xi + dx;
        y_nxt[k] = yi - dy;
        z_nxt[k] = zi + ang;
      end else begin
        x_nxt[k] = xi - dx;
        y_nxt[k] = yi + dy;
        z_nxt[k] = zi - ang;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      z_r    <= z_nxt;
      s_r    <= s_nxt;
      side_r <= side_nxt;
    end
  end

  assign out_vld  = vld_r[N-1];
  assign out_t    = z_r[N-1];
  assign out_s    = s_r[N-1];
  assign out_side = side_r[N-1];

endmodule
`default_nettype wire

@@ design/qerv_div.sv @@
// pipelined restoring divider: f = floor(2t / s), one quotient bit per stage
`default_nettype none
module qerv_div (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_vld,
  input  logic signed [63:0] in_t,
  input  logic [31:0]        in_s,
  input  qerv_pkg::side_t    in_side,
  output logic               out_vld,
  output logic [31:0]        out_q,
  output logic               out_zero,
  output qerv_pkg::side_t    out_side
);

  localparam int N = qerv_pkg::DivSteps;

  logic [N-1:0]     vld_r, vld_nxt;
  logic [31:0]      rem_r [N];
  logic [31:0]      rem_nxt [N];
  logic [31:0]      lo_r [N];
  logic [31:0]      lo_nxt [N];
  logic [31:0]      q_r [N];
  logic [31:0]      q_nxt [N];
  logic [31:0]      s_r [N];
  logic [31:0]      s_nxt [N];
  qerv_pkg::side_t  side_r [N];
  qerv_pkg::side_t  side_nxt [N];

  always_comb begin
    for (int k = 0; k < N; k++) begin
      logic [62:0] num;
      logic [31:0] rem_i, lo_i, q_i, s_i;
      logic [32:0] sh;
      num = in_t[63] ? '0 : {in_t[61:0], 1'b0};
      if (k == 0) begin
        rem_i       = {1'b0, num[62:32]};
        lo_i        = num[31:0];
        q_i         = '0;
        s_i         = in_s;
        vld_nxt[k]  = in_vld;
        side_nxt[k] = in_side;
      end else begin
        rem_i       = rem_r[k-1];
        lo_i        = lo_r[k-1];
        q_i         = q_r[k-1];
        s_i         = s_r[k-1];
        vld_nxt[k]  = vld_r[k-1];
        side_nxt[k] = side_r[k-1];
      end
      sh = {rem_i, lo_i[31]};
      if (sh >= {1'b0, s_i}) begin
        rem_nxt[k] = 32'(sh - {1'b0, s_i});
        q_nxt[k]   = {q_i[30:0], 1'b1};
      end else begin
        rem_nxt[k] = sh[31:0];
        q_nxt[k]   = {q_i[30:0], 1'b0};
      end
      lo_nxt[k] = lo_i << 1;
      s_nxt[k]  = s_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= rem_nxt;
      lo_r   <= lo_nxt;
      q_r    <= q_nxt;
      s_r    <= s_nxt;
      side_r <= side_nxt;
    end
  end

  assign out_vld  = vld_r[N-1];
  assign out_q    = q_r[N-1];
  assign out_zero = (s_r[N-1] == 32'd0);
  assign out_side = side_r[N-1];

endmodule
`default_nettype wire

@@ design/quaternion_error_rotation_vector.sv @@
// top level: rotation vector between two unit quaternions (quaternion box-minus)
//
//   channel | direction | tdata fields, lowest bit up
//   in_     | slave     | ref_w ref_x ref_y ref_z other_w other_x other_y other_z, 32 b each
//   out_    | master    | rot_x rot_y rot_z, 31 b each, 3 zero pad bits on top
//
// one pair enters per cycle of enabled clock; the pipeline is made of
// 5 front stages, 32 root stages, 60 cordic stages, 32 divider stages,
// then one multiply stage and one round/saturate output register
// all stages share one enable that drops only while the output register
// holds a result that is not taken; a stall freezes every stage in place
// reset clears the valid bits only, the data registers are not reset
`default_nettype none
module quaternion_error_rotation_vector (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [255:0] in_tdata,   // ref_w, ref_x, ref_y, ref_z, other_w, other_x, other_y, other_z
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [95:0]  out_tdata   // rot_x, rot_y, rot_z, zero pad
);

  logic en;

  // front end to root
  logic            fr_vld;
  logic [30:0]     fr_c;
  logic [62:0]     fr_a;
  qerv_pkg::side_t fr_side;

  // root to cordic
  logic            sq_vld;
  logic [31:0]     sq_s;
  logic [30:0]     sq_c;
  qerv_pkg::side_t sq_side;

  // cordic to divider
  logic               cd_vld;
  logic signed [63:0] cd_t;
  logic [31:0]        cd_s;
  qerv_pkg::side_t    cd_side;

  // divider out
  logic            dv_vld;
  logic [31:0]     dv_q;
  logic            dv_zero;
  qerv_pkg::side_t dv_side;

  // scale stage
  logic               mul_vld_r;
  logic signed [66:0] px_r, py_r, pz_r;
  logic signed [66:0] px_nxt, py_nxt, pz_nxt;
  logic signed [30:0] rot_x_r, rot_y_r, rot_z_r;
  logic signed [30:0] rot_x_nxt, rot_y_nxt, rot_z_nxt;
  logic               out_vld_r;

  // pipeline moves unless a finished result is waiting
  assign en        = !out_vld_r || out_tready;
  assign in_tready = en;

  qerv_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (in_tvalid),
    .in_data  (in_tdata),
    .out_vld  (fr_vld),
    .out_c    (fr_c),
    .out_a    (fr_a),
    .out_side (fr_side)
  );

  qerv_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (fr_vld),
    .in_a     (fr_a),
    .in_c     (fr_c),
    .in_side  (fr_side),
    .out_vld  (sq_vld),
    .out_s    (sq_s),
    .out_c    (sq_c),
    .out_side (sq_side)
  );

  qerv_cordic u_cordic (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (sq_vld),
    .in_c     (sq_c),
    .in_s     (sq_s),
    .in_side  (sq_side),
    .out_vld  (cd_vld),
    .out_t    (cd_t),
    .out_s    (cd_s),
    .out_side (cd_side)
  );

  qerv_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (cd_vld),
    .in_t     (cd_t),
    .in_s     (cd_s),
    .in_side  (cd_side),
    .out_vld  (dv_vld),
    .out_q    (dv_q),
    .out_zero (dv_zero),
    .out_side (dv_side)
  );

  // scale factor in q.29: exactly 2 at zero half angle
  always_comb begin
    logic signed [32:0] f;
    f = dv_zero ? 33'sd1073741824 : $signed({1'b0, dv_q});
    px_nxt = dv_side.vx * f;
    py_nxt = dv_side.vy * f;
    pz_nxt = dv_side.vz * f;
  end

  // round half up to q3.28 and saturate
  function automatic logic signed [30:0] round_sat(input logic signed [66:0] p);
    logic signed [66:0] r;
    r = (p + 67'sd1073741824) >>> 31;
    if (r > 67'(qerv_pkg::RotLimit)) return qerv_pkg::RotLimit;
    else if (r < -67'(qerv_pkg::RotLimit)) return -qerv_pkg::RotLimit;
    else return r[30:0];
  endfunction

  assign rot_x_nxt = round_sat(px_r);
  assign rot_y_nxt = round_sat(py_r);
  assign rot_z_nxt = round_sat(pz_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (en) begin
      mul_vld_r <= dv_vld;
      out_vld_r <= mul_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      px_r    <= px_nxt;
      py_r    <= py_nxt;
      pz_r    <= pz_nxt;
      rot_x_r <= rot_x_nxt;
      rot_y_r <= rot_y_nxt;
      rot_z_r <= rot_z_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {3'b000, rot_z_r, rot_y_r, rot_x_r};

`ifndef SYNTHESIS
  a_rot_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (rot_x_r <= qerv_pkg::RotLimit) && (rot_x_r >= -qerv_pkg::RotLimit) &&
                  (rot_y_r <= qerv_pkg::RotLimit) && (rot_y_r >= -qerv_pkg::RotLimit) &&
                  (rot_z_r <= qerv_pkg::RotLimit) && (rot_z_r >= -qerv_pkg::RotLimit))
    else $error("rotation component beyond limit");

  a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(mul_vld_r) && $stable(dv_vld) && $stable(dv_q))
    else $error("pipeline moved during stall");

  a_quot_bound: assert property (@(posedge clk) disable iff (!rst_n)
    dv_vld && !dv_zero |-> !dv_q[31])
    else $error("scale factor out of range");
`endif

endmodule
`default_nettype wire

@@ tb/sv/tb.sv @@
// testbench for the quaternion box-minus block: bit-exact prediction with a scoreboard
`default_nettype none

class rotvec_scoreboard;
  typedef struct {
    logic signed [30:0] x;
    logic signed [30:0] y;
    logic signed [30:0] z;
  } rotvec_t;

  localparam longint One30 = 64'sd1 << 30;
  localparam longint RotMax = 64'sd843314857;

  rotvec_t           expected_q[$];
  int                errors;
  longint unsigned   atan_tab[60];

  function new();
    errors = 0;
    atan_tab[0] = 4 * arctan_inv(64'd5) - arctan_inv(64'd239);
    for (int i = 1; i < 60; i++) begin
      atan_tab[i] = (i <= 30) ? arctan_inv(64'd1 << i) : ((64'd1 << 60) >> i);
    end
  endfunction

  // atan(1/n) in Q.60, truncated series
  function longint unsigned arctan_inv(longint unsigned n);
    longint unsigned nn, term, sum, k, q;
    nn = n * n;
    term = (64'd1 << 60) / n;
    sum = 0;
    k = 0;
    while (term != 0) begin
      q = term / (2 * k + 1);
      if (k[0]) sum = sum - q;
      else sum = sum + q;
      term = term / nn;
      k++;
    end
    return sum;
  endfunction

  function longint clamp_q30(logic [31:0] raw);
    longint v;
    v = longint'($signed(raw));
    if (v > One30) v = One30;
    if (v < -One30) v = -One30;
    return v;
  endfunction

  function longint round_q30(longint v);
    return (v + (64'sd1 << 29)) >>> 30;
  endfunction

  function longint unsigned int_sqrt(longint unsigned a);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > a) b = b >> 2;
    while (b != 0) begin
      if (a >= r + b) begin
        a = a - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function longint half_angle(longint x, longint y);
    longint z, dx, dy;
    z = 0;
    for (int i = 0; i < 60; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x = x + dx;
        y = y - dy;
        z = z + longint'(atan_tab[i]);
      end else begin
        x = x - dx;
        y = y + dy;
        z = z - longint'(atan_tab[i]);
      end
    end
    return z;
  endfunction

  function logic signed [30:0] scale_part(longint v, longint f);
    longint r;
    r = (v * f + One30) >>> 31;
    if (r > RotMax) r = RotMax;
    if (r < -RotMax) r = -RotMax;
    return r[30:0];
  endfunction

  function rotvec_t box_minus(logic [255:0] d);
    longint aw, ax, ay, az, bw, bx, by, bz, dw, vx, vy, vz, c, f, t;
    longint unsigned s;
    rotvec_t r;
    bw = clamp_q30(d[31:0]);
    bx = -clamp_q30(d[63:32]);
    by = -clamp_q30(d[95:64]);
    bz = -clamp_q30(d[127:96]);
    aw = clamp_q30(d[159:128]);
    ax = clamp_q30(d[191:160]);
    ay = clamp_q30(d[223:192]);
    az = clamp_q30(d[255:224]);
    dw = round_q30(aw * bw - ax * bx - ay * by - az * bz);
    vx = round_q30(aw * bx + ax * bw + ay * bz - az * by);
    vy = round_q30(aw * by + ay * bw + az * bx - ax * bz);
    vz = round_q30(aw * bz + az * bw + ax * by - ay * bx);
    // keep the short way round
    if (dw < 0) begin
      dw = -dw;
      vx = -vx;
      vy = -vy;
      vz = -vz;
    end
    c = (dw > One30) ? One30 : dw;
    s = int_sqrt(((64'd1 << 60) - longint'(c) * longint'(c)) << 2);
    if (s == 0) begin
      f = One30;  // zero angle: factor is exactly two
    end else begin
      t = half_angle(c << 30, longint'(s << 29));
      if (t < 0) t = 0;
      f = longint'((unsigned'(t) * 64'd2) / s);
    end
    r.x = scale_part(vx, f);
    r.y = scale_part(vy, f);
    r.z = scale_part(vz, f);
    return r;
  endfunction

  function void note_input(logic [255:0] d);
    expected_q.push_back(box_minus(d));
  endfunction

  function void check_result(logic [95:0] d);
    rotvec_t e;
    if (expected_q.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected result %h", d);
      return;
    end
    e = expected_q.pop_front();
    if (d[30:0] !== e.x || d[61:31] !== e.y || d[92:62] !== e.z) begin
      errors++;
      if (errors <= 10)
        $display("mismatch: expected x=%0d y=%0d z=%0d got x=%0d y=%0d z=%0d",
                 e.x, e.y, e.z, $signed(d[30:0]), $signed(d[61:31]), $signed(d[92:62]));
    end
  endfunction

  function int pending();
    return expected_q.size();
  endfunction
endclass

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [255:0] in_tdata;   // ref_w, ref_x, ref_y, ref_z, other_w, other_x, other_y, other_z
  logic         out_tvalid;
  logic         out_tready;
  logic [95:0]  out_tdata;  // rot_x, rot_y, rot_z, zero pad

  rotvec_scoreboard sb;
  bit               no_idle;  // stretch with neither side idling

  quaternion_error_rotation_vector DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // mostly short gaps, a few long ones
  function int gap_len();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // accepted transfers on both channels
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) sb.note_input(in_tdata);
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  // receiver side back-pressure
  initial begin
    int g;
    out_tready = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      g = gap_len();
      if (g > 0) begin
        out_tready <= 1'b0;
        repeat (g) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
    end
  end

  // one transfer: optional idle gap, then hold valid until taken
  task automatic send(input logic [255:0] d);
    int  g;
    bit  hit;
    g = gap_len();
    if (g > 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    do begin
      @(negedge clk);
      hit = in_tready;
      @(posedge clk);
    end while (!hit);
  endtask

  function logic [31:0] to_q30(real v);
    return 32'($rtoi(v * 1073741824.0));
  endfunction

  function real rnd_unit();
    return ($urandom_range(0, 2000000) / 1000000.0) - 1.0;
  endfunction

  // pack reference and second quaternion, given as reals
  function logic [255:0] pack_pair(real r[4], real q[4]);
    logic [255:0] d;
    for (int i = 0; i < 4; i++) begin
      d[32*i +: 32]     = to_q30(r[i]);
      d[128 + 32*i +: 32] = to_q30(q[i]);
    end
    return d;
  endfunction

  function void unit_quat(output real q[4]);
    real n;
    do begin
      n = 0.0;
      for (int i = 0; i < 4; i++) begin
        q[i] = rnd_unit();
        n += q[i] * q[i];
      end
    end while (n < 0.01);
    n = $sqrt(n);
    for (int i = 0; i < 4; i++) q[i] = q[i] / n;
  endfunction

  // well-formed pair: unit reference and a unit second quaternion near or far from it
  function logic [255:0] random_pair();
    real r[4], q[4], e, n;
    int  k;
    unit_quat(r);
    k = $urandom_range(0, 9);
    if (k < 4) begin
      unit_quat(q);
    end else begin
      e = (k < 7) ? 1.0e-3 : 1.0e-6;
      if (k == 9) e = 0.0;
      n = 0.0;
      for (int i = 0; i < 4; i++) begin
        q[i] = r[i] + e * rnd_unit();
        n += q[i] * q[i];
      end
      n = $sqrt(n);
      for (int i = 0; i < 4; i++) q[i] = q[i] / n;
    end
    // sign of the second quaternion is arbitrary, exercises the flip
    if ($urandom_range(0, 1))
      for (int i = 0; i < 4; i++) q[i] = -q[i];
    return pack_pair(r, q);
  endfunction

  initial begin
    logic [255:0] d;
    real          r[4], q[4];
    sb = new();
    no_idle = 0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: identity pair, zero angle
    r = '{1.0, 0.0, 0.0, 0.0};
    send(pack_pair(r, r));
    // identical general quaternions, zero angle
    r = '{0.5, 0.5, -0.5, 0.5};
    send(pack_pair(r, r));
    // negated copy, scalar part of the difference goes negative
    q = '{-0.5, -0.5, 0.5, -0.5};
    send(pack_pair(r, q));
    // half turn about each axis
    r = '{1.0, 0.0, 0.0, 0.0};
    q = '{0.0, 1.0, 0.0, 0.0};
    send(pack_pair(r, q));
    q = '{0.0, 0.0, 1.0, 0.0};
    send(pack_pair(r, q));
    q = '{0.0, 0.0, 0.0, -1.0};
    send(pack_pair(r, q));
    // quarter turn
    q = '{0.70710678, 0.0, 0.70710678, 0.0};
    send(pack_pair(r, q));
    // all zeros, not a unit quaternion
    send('0);
    // all fields at +1 and -1 exactly
    send({8{32'h4000_0000}});
    send({8{32'hC000_0000}});
    send({{4{32'h4000_0000}}, {4{32'hC000_0000}}});
    // raw extremes out of range, saturated on entry
    send({8{32'h7FFF_FFFF}});
    send({8{32'h8000_0000}});
    send({{4{32'h8000_0000}}, {4{32'h7FFF_FFFF}}});
    send({32'h0, 32'h0, 32'h0, 32'h7FFF_FFFF, 32'h0, 32'h0, 32'h0, 32'h4000_0001});
    // one lsb apart on entry, saturation makes the pair identical, zero angle
    send({32'h0, 32'h0, 32'h0, 32'h0000_0001, 32'h0, 32'h0, 32'h0, 32'h4000_0000} |
         {96'h0, 32'h4000_0000, 128'h0});
    // vector part large, scalar small and non-unit
    send({32'h4000_0000, 32'h4000_0000, 32'h4000_0000, 32'h0000_0001,
          32'h0, 32'h0, 32'h0, 32'h4000_0000});

    // hold off until the pipeline has drained
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);

    for (int n = 0; n < 1400; n++) begin
      no_idle = ((n / 150) % 4 == 2);
      if ($urandom_range(0, 9) == 0) begin
        // noise: any bit pattern, mostly out of range
        for (int i = 0; i < 8; i++) d[32*i +: 32] = $urandom();
      end else begin
        d = random_pair();
      end
      send(d);
    end
    in_tvalid <= 1'b0;
    no_idle = 0;

    fork
      begin
        while (sb.pending() != 0) @(posedge clk);
        // extra cycles past the pipeline depth to catch stray results
        repeat (200) @(posedge clk);
      end
    join
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("quaternion_error_rotation_vector test passed");
    end else begin
      $display("quaternion_error_rotation_vector test failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5ms;
    $display("quaternion_error_rotation_vector test failed");
    $finish;
  end
endmodule

`default_nettype wire
